// ----- src/rpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants for the replay protection table.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int SEQ_W       = 24;
  localparam int SEQ_LOW_W   = 8;
  localparam int SEQ_HIGH_W  = SEQ_W - SEQ_LOW_W;
  localparam int ADDR_W      = 16;
  localparam int IV_W        = 8;

  typedef enum logic [1:0] {
    FN_CHECK  = 2'd0,
    FN_SET    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_USED = 2'd1,
    ST_NEW  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     src;
    logic [IV_W-1:0]       iv;
    logic [SEQ_HIGH_W-1:0] seq_hi;
    logic [SEQ_LOW_W-1:0]  seq_lo;
  } entry_t;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] src;
    logic [IV_W-1:0]   iv;
    logic [IV_W-1:0]   active_iv;
    logic [SEQ_W-1:0]  seq;
  } item_t;

  typedef struct packed {
    logic    accepted;
    status_t status;
  } res_t;

  // table write command
  typedef struct packed {
    logic we;
    logic inv;
    logic clr_all;
  } wr_cmd_t;

endpackage

// ----- src/rpt_if.sv -----
// ----------------------------------------------------------------------------
// rpt_if
// Valid/ready channels for the replay protection table.
// ----------------------------------------------------------------------------
interface rpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] src_addr;
  logic [7:0]  iv_flag;
  logic [7:0]  active_iv_flag;
  logic [23:0] seq_num;

  modport source (output valid, func, src_addr, iv_flag, active_iv_flag, seq_num,
                  input ready);
  modport sink   (input valid, func, src_addr, iv_flag, active_iv_flag, seq_num,
                  output ready);
endinterface

interface rpt_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] status;

  modport source (output valid, accepted, status, input ready);
  modport sink   (input valid, accepted, status, output ready);
endinterface

// ----- src/rpt_store.sv -----
// ----------------------------------------------------------------------------
// rpt_store
// Entry memory with per-entry valid bits and a registered read port.
// ----------------------------------------------------------------------------
module rpt_store #(
  parameter int ENTRIES = rpt_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output rpt_pkg::entry_t  rd_ent,
  output logic             rd_vld,
  input  rpt_pkg::wr_cmd_t wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  rpt_pkg::entry_t  wr_ent
);
  import rpt_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  entry_t             rd_ent_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_idx] <= wr_ent;
    end
    rd_ent_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_idx];
      if (wr.clr_all) begin
        valid_r <= '0;
      end else if (wr.we) begin
        valid_r[wr_idx] <= 1'b1;
      end else if (wr.inv) begin
        valid_r[wr_idx] <= 1'b0;
      end
    end
  end

  assign rd_ent = rd_ent_r;
  assign rd_vld = rd_vld_r;

endmodule

// ----- src/rpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpt_ctrl
// Scan sequencer: walks the table one entry per cycle through a single
// source comparator, then resolves and applies the operation.
// ----------------------------------------------------------------------------
module rpt_ctrl #(
  parameter int ENTRIES = rpt_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rpt_pkg::item_t   in_item,
  output logic             res_valid,
  input  logic             res_ready,
  output rpt_pkg::res_t    res,
  output logic [IDX_W-1:0] rd_idx,
  input  rpt_pkg::entry_t  rd_ent,
  input  logic             rd_vld,
  output rpt_pkg::wr_cmd_t wr,
  output logic [IDX_W-1:0] wr_idx,
  output rpt_pkg::entry_t  wr_ent
);
  import rpt_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t           state_r, state_nxt;
  item_t            item_r;
  logic [CNT_W-1:0] scan_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  entry_t           hit_ent_r;
  logic             emp_r;
  logic [IDX_W-1:0] emp_idx_r;

  logic             scan_more;
  logic             match;
  logic             is_empty;
  logic [SEQ_W-1:0] stored_seq;
  logic             same_iv;
  entry_t           new_ent;

  assign scan_more = (scan_r != LAST);
  assign rd_idx    = scan_more ? scan_r[IDX_W-1:0] : '0;
  assign match     = rd_vld && (rd_ent.src == item_r.src) && (item_r.src != '0);
  assign is_empty  = !rd_vld;
  assign in_ready  = (state_r == IDLE);

  assign stored_seq = {hit_ent_r.seq_hi, hit_ent_r.seq_lo};
  assign same_iv    = (hit_ent_r.iv == item_r.iv);
  assign new_ent    = '{src: item_r.src, iv: item_r.iv,
                        seq_hi: item_r.seq[SEQ_W-1:SEQ_LOW_W],
                        seq_lo: item_r.seq[SEQ_LOW_W-1:0]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      IDLE:    if (in_valid) state_nxt = SCAN;
      SCAN:    if (!scan_more) state_nxt = FINISH;
      FINISH:  if (res_ready) state_nxt = IDLE;
      default: state_nxt = IDLE;
    endcase
  end

  always_comb begin
    res       = '{accepted: 1'b0, status: ST_NONE};
    wr        = '0;
    wr_idx    = hit_idx_r;
    wr_ent    = new_ent;
    res_valid = (state_r == FINISH);
    case (item_r.func)
      FN_CHECK: begin
        res.accepted = !hit_r || (same_iv && (stored_seq < item_r.seq)) ||
                       (!same_iv && (item_r.active_iv == item_r.iv));
        res.status   = hit_r ? ST_USED : ST_NONE;
      end
      FN_SET: begin
        if (item_r.src != '0) begin
          if (hit_r) begin
            res.status = ST_USED;
            wr.we      = 1'b1;
          end else if (emp_r) begin
            res.status = ST_NEW;
            wr.we      = 1'b1;
            wr_idx     = emp_idx_r;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      FN_REMOVE: begin
        if (hit_r) begin
          res.status = ST_USED;
          wr.inv     = 1'b1;
        end
      end
      FN_CLEAR: wr.clr_all = 1'b1;
      default:  res = '{accepted: 1'b0, status: ST_NONE};
    endcase
    if (!(res_valid && res_ready)) begin
      wr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      IDLE: begin
        item_r    <= in_item;
        scan_r    <= '0;
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
        emp_r     <= 1'b0;
      end
      SCAN: begin
        cmp_vld_r <= scan_more;
        cmp_idx_r <= rd_idx;
        if (scan_more) begin
          scan_r <= scan_r + 1'b1;
        end
        if (cmp_vld_r && match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
          hit_ent_r <= rd_ent;
        end
        if (cmp_vld_r && is_empty && !emp_r) begin
          emp_r     <= 1'b1;
          emp_idx_r <= cmp_idx_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/replay_protection_table.sv -----
// ----------------------------------------------------------------------------
// replay_protection_table
// Per-source replay protection list with check, set, remove and clear.
// ----------------------------------------------------------------------------
// Each item is handled by scanning the table one entry per cycle through the
// single read port of the entry memory, and the block takes no new item until
// the current one is done: it accepts the item, scans the table with its
// registered read, and then resolves and writes back. The
// result goes to an output register, so it may wait for the sink while the
// next item is taken. All entries are empty after reset and after clear.
module replay_protection_table #(
  parameter int ENTRIES = rpt_pkg::ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rpt_in_if.sink    in_ch,
  rpt_out_if.source out_ch
);
  import rpt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  item_t            in_item;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_ent;
  logic             rd_vld;
  wr_cmd_t          wr;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_ent;

  logic             out_valid_r;
  res_t             out_res_r;

  assign in_item = '{func: func_t'(in_ch.func), src: in_ch.src_addr, iv: in_ch.iv_flag,
                     active_iv: in_ch.active_iv_flag, seq: in_ch.seq_num};

  rpt_ctrl #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .rd_idx   (rd_idx),
    .rd_ent   (rd_ent),
    .rd_vld   (rd_vld),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .wr_ent   (wr_ent)
  );

  rpt_store #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_idx(rd_idx),
    .rd_ent(rd_ent),
    .rd_vld(rd_vld),
    .wr    (wr),
    .wr_idx(wr_idx),
    .wr_ent(wr_ent)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.accepted = out_res_r.accepted;
  assign out_ch.status   = out_res_r.status;

endmodule

// ----- src/rpt_chk.sv -----
// ----------------------------------------------------------------------------
// rpt_chk
// Port-level checks for the replay protection table.
// ----------------------------------------------------------------------------
module rpt_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic [1:0] out_status
);
  import rpt_pkg::*;

  // a beat starts a scan; no new beat is taken straight after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken during scan");

  // accepted only comes with check outcomes
  a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_status == ST_NONE || out_status == ST_USED)
    else $error("accepted with set/full status");

  // a result beat needs an item that finished its scan
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) && $stable(out_status))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind replay_protection_table rpt_chk u_rpt_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_accepted(out_ch.accepted),
  .out_status  (out_ch.status)
);
